// ----- rtl/core/hsa_pkg.sv -----
// Shared constants and helpers for the HSL saturation adjust block.
`default_nettype none

package hsa_pkg;

  // Default fraction width of the lightness/saturation terms.
  localparam int FRAC_BITS_DEF = 16;

  // Gain format: unsigned Q11.12, clipped at GAIN_MAX.
  localparam int GAIN_FRAC = 12;
  localparam int GAIN_MAX  = 8388607;
  localparam int GAIN_W    = 23;

  // Saturation amount limits, in percent.
  localparam int AMT_MAX = 100;

  // Start-to-strobe latency in cycles.
  function automatic int hsa_latency(input int frac_bits);
    return 2 * frac_bits + 28;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hsa_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side data.
`default_nettype none

module hsa_div_pipe
  import hsa_pkg::*;
#(
  parameter int NW = 24,
  parameter int DW = 8,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side,
  output logic               out_valid,
  output logic      [NW-1:0] quo,
  output logic      [SW-1:0] out_side
);

  logic          vld    [1:NW];
  logic [DW-1:0] rem    [1:NW];
  logic [NW-1:0] num_s  [1:NW];
  logic [NW-1:0] quo_s  [1:NW];
  logic [DW-1:0] den_s  [1:NW];
  logic [SW-1:0] side_s [1:NW];

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_rem;
    logic [NW-1:0] p_num;
    logic [NW-1:0] p_quo;
    logic [DW-1:0] p_den;
    logic [SW-1:0] p_side;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 1) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_num  = num;
      assign p_quo  = '0;
      assign p_den  = den;
      assign p_side = side;
    end else begin : g_next
      assign p_vld  = vld[k-1];
      assign p_rem  = rem[k-1];
      assign p_num  = num_s[k-1];
      assign p_quo  = quo_s[k-1];
      assign p_den  = den_s[k-1];
      assign p_side = side_s[k-1];
    end

    assign trial = {p_rem, p_num[NW-1]};
    assign ge    = (trial >= {1'b0, p_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem[k]    <= ge ? DW'(trial - {1'b0, p_den}) : DW'(trial);
      num_s[k]  <= {p_num[NW-2:0], 1'b0};
      quo_s[k]  <= {p_quo[NW-2:0], ge};
      den_s[k]  <= p_den;
      side_s[k] <= p_side;
    end
  end

  assign out_valid = vld[NW];
  assign quo       = quo_s[NW];
  assign out_side  = side_s[NW];

endmodule

`default_nettype wire

// ----- rtl/core/hsl_saturation_adjust.sv -----
// Top level of the HSL saturation adjust pipeline for 8-bit BGR pixels.
`default_nettype none

// Usage
//   Input: drive blue_in/green_in/red_in with start high; a word is taken at
//   every rising edge where start is high and busy is low. busy stays low, so
//   a new pixel may enter on every cycle.
//   Output: each result word shows on blue_out/green_out/red_out for one
//   cycle with strobe high. The receiver takes it on that cycle; there is no
//   back-pressure.
//   Configuration: saturation_amount is written when amount_we is high. Write
//   only while no pixel is in flight.
//   Pipeline: start to strobe runs through stages 1 and 2, the saturation
//   divider (FRAC_BITS+8 stages), stage T, the gain reciprocal divider
//   (FRAC_BITS+13 stages) and stages G, M, A and Q.
//   Throughput: one pixel per cycle, sustained.
//   Reset: rst clears all valid bits, the strobe and the amount (to zero).
module hsl_saturation_adjust
  import hsa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              amount_we,
  input  wire logic signed [7:0] saturation_amount,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic        [7:0] blue_in,
  input  wire logic        [7:0] green_in,
  input  wire logic        [7:0] red_in,
  output logic                   strobe,
  output logic             [7:0] blue_out,
  output logic             [7:0] green_out,
  output logic             [7:0] red_out
);

  localparam int NW1 = FRAC_BITS + 8;
  localparam int NW2 = FRAC_BITS + 13;
  localparam int TW  = FRAC_BITS + 1;
  localparam int SW  = 34;
  localparam int CW  = ((NW2 > GAIN_W + 1) ? NW2 : GAIN_W + 1) + 1;

  // Configuration register and the per-amount terms derived from it.
  logic signed [7:0] amount;
  logic signed [7:0] amt_c;
  logic        [6:0] amt_idx;
  logic              pos_q;
  logic     [TW-1:0] lim_q;
  logic        [6:0] f_q;
  logic     [TW-1:0] lim_tab [0:AMT_MAX];

  // Rounded Q1.FRAC_BITS value of 1 - amount/100, built at elaboration.
  for (genvar k = 0; k <= AMT_MAX; k++) begin : g_lim
    localparam longint unsigned LV =
      ((64'(AMT_MAX - k) << FRAC_BITS) + 64'd50) / 64'd100;
    assign lim_tab[k] = TW'(LV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amount <= '0;
    end else if (amount_we) begin
      amount <= saturation_amount;
    end
  end

  // Clamp the amount to +/-100 percent.
  always_comb begin
    if (amount > 8'sd100) begin
      amt_c = 8'sd100;
    end else if (amount < -8'sd100) begin
      amt_c = -8'sd100;
    end else begin
      amt_c = amount;
    end
    amt_idx = (amt_c > 8'sd0) ? amt_c[6:0] : 7'd0;
  end

  // Refresh each cycle; user moves amount only while pipe is empty, unchecked.
  always_ff @(posedge clk) begin
    pos_q <= (amt_c > 8'sd0);
    lim_q <= lim_tab[amt_idx];
    f_q   <= 7'(8'(amt_c) + 8'd100);
  end

  assign busy = 1'b0;

  // Stage 1: capture the input word.
  logic       s1_vld;
  logic [7:0] s1_ch [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_ch[0] <= blue_in;
    s1_ch[1] <= green_in;
    s1_ch[2] <= red_in;
  end

  // Stage 2: max, min, lightness sum and divider operands.
  logic       s2_vld;
  logic [7:0] s2_ch [3];
  logic [8:0] s2_mid;
  logic [7:0] s2_delta;
  logic [7:0] s2_den;
  logic       s2_grey;
  logic [7:0] mx;
  logic [7:0] mn;
  logic [8:0] mid_c;

  always_comb begin
    mx = s1_ch[0];
    mn = s1_ch[0];
    for (int i = 1; i < 3; i++) begin
      if (s1_ch[i] > mx) mx = s1_ch[i];
      if (s1_ch[i] < mn) mn = s1_ch[i];
    end
    mid_c = 9'(mx) + 9'(mn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_ch    <= s1_ch;
    s2_mid   <= mid_c;
    s2_delta <= mx - mn;
    s2_den   <= (mid_c <= 9'd255) ? mid_c[7:0] : 8'(9'd510 - mid_c);
    s2_grey  <= (mx == mn);
  end

  // Divider 1: saturation S = round(delta << FRAC_BITS / den).
  logic [NW1-1:0] n1;
  logic [SW-1:0]  side1;
  logic           d1_vld;
  logic [NW1-1:0] d1_quo;
  logic [SW-1:0]  d1_side;

  assign n1    = {s2_delta, FRAC_BITS'(0)} + NW1'(s2_den[7:1]);
  assign side1 = {s2_grey, s2_mid, s2_ch[2], s2_ch[1], s2_ch[0]};

  hsa_div_pipe #(.NW(NW1), .DW(8), .SW(SW)) u_div_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_vld),
    .num       (n1),
    .den       (s2_den),
    .side      (side1),
    .out_valid (d1_vld),
    .quo       (d1_quo),
    .out_side  (d1_side)
  );

  // Stage T: pick the larger of S and the limit, set up the reciprocal.
  logic          st_vld;
  logic [TW-1:0] st_t;
  logic [NW2-1:0] st_n2;
  logic [SW-1:0] st_side;
  logic [TW-1:0] s_val;
  logic [TW-1:0] t_c;

  always_comb begin
    s_val = d1_quo[TW-1:0];
    t_c   = (s_val > lim_q) ? s_val : lim_q;
    if (t_c == '0) t_c = TW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= 1'b0;
    end else begin
      st_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    st_t    <= t_c;
    st_n2   <= (NW2'(1) << (FRAC_BITS + GAIN_FRAC)) + NW2'(t_c >> 1);
    st_side <= d1_side;
  end

  // Divider 2: reciprocal round(2^(FRAC_BITS+12) / t).
  logic           d2_vld;
  logic [NW2-1:0] d2_quo;
  logic [SW-1:0]  d2_side;

  hsa_div_pipe #(.NW(NW2), .DW(TW), .SW(SW)) u_div_rcp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_vld),
    .num       (st_n2),
    .den       (st_t),
    .side      (st_side),
    .out_valid (d2_vld),
    .quo       (d2_quo),
    .out_side  (d2_side)
  );

  // Stage G: gain = reciprocal - 1.0, clipped at the top.
  logic              g_vld;
  logic [GAIN_W-1:0] g_gain;
  logic [SW-1:0]     g_side;
  logic [CW-1:0]     rcp_x;
  logic [CW-1:0]     gain_x;

  always_comb begin
    rcp_x  = CW'(d2_quo);
    gain_x = rcp_x - CW'(1 << GAIN_FRAC);
    if (gain_x > CW'(GAIN_MAX)) gain_x = CW'(GAIN_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else begin
      g_vld <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    g_gain <= gain_x[GAIN_W-1:0];
    g_side <= d2_side;
  end

  // Stage M: multiply the channel offsets by the gain and by the factor.
  logic               m_vld;
  logic signed [33:0] m_pp [3];
  logic signed [17:0] m_pn [3];
  logic         [7:0] m_ch [3];
  logic         [8:0] m_mid;
  logic               m_grey;
  logic signed  [9:0] diff [3];
  logic         [7:0] g_ch [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_ch[i] = g_side[8*i +: 8];
      diff[i] = $signed({1'b0, g_ch[i], 1'b0}) - $signed({1'b0, g_side[32:24]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m_pp[i] <= diff[i] * $signed({1'b0, g_gain});
      m_pn[i] <= diff[i] * $signed({1'b0, f_q});
      m_ch[i] <= g_ch[i];
    end
    m_mid  <= g_side[32:24];
    m_grey <= g_side[33];
  end

  // Stage A: sums, rounding and range checks for both paths.
  logic               a_vld;
  logic         [7:0] a_rp [3];
  logic        [12:0] a_n8 [3];
  logic               a_nz [3];
  logic               a_ns [3];
  logic         [7:0] a_ch [3];
  logic               a_grey;
  logic signed [35:0] np [3];
  logic signed [35:0] np_sh [3];
  logic signed [18:0] nn [3];
  logic         [7:0] rp [3];
  logic        [16:0] mid_x100;

  always_comb begin
    mid_x100 = 17'(m_mid) * 17'd100;
    for (int i = 0; i < 3; i++) begin
      np[i] = $signed({15'b0, m_ch[i], 13'b0}) + 36'(m_pp[i])
            + 36'sd4096;
      np_sh[i] = np[i] >>> (GAIN_FRAC + 1);
      if (np[i] < 0) begin
        rp[i] = 8'd0;
      end else if (np_sh[i] > 36'sd255) begin
        rp[i] = 8'd255;
      end else begin
        rp[i] = np_sh[i][7:0];
      end
      nn[i] = $signed({2'b0, mid_x100}) + 19'(m_pn[i]) + 19'sd100;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_rp[i] <= rp[i];
      a_n8[i] <= nn[i][15:3];
      a_nz[i] <= (nn[i] < 0);
      a_ns[i] <= (nn[i] >= 19'sd51200);
      a_ch[i] <= m_ch[i];
    end
    a_grey <= m_grey;
  end

  // Stage Q: divide by 25 through a reciprocal, select and drive the word.
  logic [25:0] qprod [3];
  logic  [7:0] res   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qprod[i] = 26'(a_n8[i]) * 26'd5243;
      if (a_grey) begin
        res[i] = a_ch[i];
      end else if (pos_q) begin
        res[i] = a_rp[i];
      end else if (a_nz[i]) begin
        res[i] = 8'd0;
      end else if (a_ns[i]) begin
        res[i] = 8'd255;
      end else begin
        res[i] = qprod[i][24:17];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    blue_out  <= res[0];
    green_out <= res[1];
    red_out   <= res[2];
  end

endmodule

`default_nettype wire

// ----- rtl/core/hsa_checker.sv -----
// Port-level checker for the HSL saturation adjust block, with its bind.
`default_nettype none

module hsa_checker
  import hsa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              amount_we,
  input wire logic signed [7:0] saturation_amount,
  input wire logic              start,
  input wire logic              busy,
  input wire logic        [7:0] blue_in,
  input wire logic        [7:0] green_in,
  input wire logic        [7:0] red_in,
  input wire logic              strobe,
  input wire logic        [7:0] blue_out,
  input wire logic        [7:0] green_out,
  input wire logic        [7:0] red_out
);

  localparam int LAT = hsa_latency(FRAC_BITS);

  // The pipe never refuses a word.
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // Every result word traces back to a start at the depth hsa_latency gives.
  a_strobe_lat: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start, LAT))
    else $error("strobe without matching start");

  // A grey pixel comes out unchanged.
  a_grey_pass: assert property (@(posedge clk) disable iff (rst)
    (strobe && $past(blue_in == green_in && green_in == red_in, LAT)) |->
    (blue_out == $past(blue_in, LAT) && green_out == $past(green_in, LAT) &&
     red_out == $past(red_in, LAT)))
    else $error("grey pixel altered");

endmodule

bind hsl_saturation_adjust hsa_checker #(.FRAC_BITS(FRAC_BITS)) u_hsa_checker (.*);

`default_nettype wire
